// ===== hdl/fbc_pkg.sv =====
// Shared types and constants for the fractionating byte cipher.
// No dependencies; the other files, apart from fbc_if, refer to it by scoped names.
package fbc_pkg;

    // Key layout: 16 column symbols, 16 row symbols, then a 16x16 square.
    localparam int unsigned SIDE      = 16;
    localparam int unsigned SYM_BYTES = 2 * SIDE;
    localparam int unsigned KEY_BYTES = SYM_BYTES + SIDE * SIDE;

    // Item codes.
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_DATA = 1'b1;
    localparam logic MODE_ENC = 1'b0;
    localparam logic MODE_DEC = 1'b1;

    // Sequencer states, one-hot.
    typedef enum logic [8:0] {
        S_IDLE      = 9'b000000001,
        S_ENC_SCAN  = 9'b000000010,
        S_ENC_COL   = 9'b000000100,
        S_ENC_ROW   = 9'b000001000,
        S_ENC_FIN   = 9'b000010000,
        S_DEC_CSCAN = 9'b000100000,
        S_DEC_RSCAN = 9'b001000000,
        S_DEC_READ  = 9'b010000000,
        S_DEC_FIN   = 9'b100000000
    } t_state;

    // Access bundle from the sequencer to the key store.
    typedef struct packed {
        logic       sym_we;
        logic [4:0] sym_waddr;
        logic       sq_we;
        logic [7:0] sq_waddr;
        logic [7:0] wdata;
        logic [4:0] sym_raddr;
        logic [7:0] sq_raddr;
    } t_key_req;

endpackage

// ===== hdl/fbc_if.sv =====
// Valid/ready channel interfaces for the fractionating byte cipher.
// Stand-alone; used by the top level ports.
interface fbc_in_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [8:0] key_index;
    logic [7:0] value;
    logic       first;

    modport source (output valid, op, key_index, value, first, input ready);
    modport sink (input valid, op, key_index, value, first, output ready);
endinterface

interface fbc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;

    modport source (output valid, out_byte, input ready);
    modport sink (input valid, out_byte, output ready);
endinterface

// ===== hdl/fbc_key_mem.sv =====
// Key storage: the 32-byte symbol memory and the 256-byte square memory.
// Each has one write port and one registered read port. Uses fbc_pkg.
module fbc_key_mem (
    input  logic              i_clk,
    input  fbc_pkg::t_key_req i_req,
    output logic [7:0]        o_sym_rdata,
    output logic [7:0]        o_sq_rdata
);

    logic [7:0] r_sym [fbc_pkg::SYM_BYTES];
    logic [7:0] r_sq  [fbc_pkg::SIDE * fbc_pkg::SIDE];

    // Symbol memory: column symbols at 0-15, row symbols at 16-31.
    always_ff @(posedge i_clk) begin
        if (i_req.sym_we) begin
            r_sym[i_req.sym_waddr] <= i_req.wdata;
        end
        o_sym_rdata <= r_sym[i_req.sym_raddr];
    end

    // Square memory, row-major: address is {row, col}.
    always_ff @(posedge i_clk) begin
        if (i_req.sq_we) begin
            r_sq[i_req.sq_waddr] <= i_req.wdata;
        end
        o_sq_rdata <= r_sq[i_req.sq_raddr];
    end

endmodule

// ===== hdl/fractionating_byte_cipher.sv =====
// Top level of the fractionating byte cipher: sequencer, scan unit, output register.
// Depends on fbc_pkg, fbc_if (fbc_in_if, fbc_out_if) and fbc_key_mem.
//
//  Channel   Dir  Handshake       Contents
//  i_in      in   valid/ready     op, key_index, value, first
//  o_out     out  valid/ready     out_byte
//  i_cfg     in   write enable    mode (1 bit)
//
// A load beat is written straight into the key store and leaves the block idle. An
// encrypting beat scans the square one entry per cycle through the compare unit, which
// acts on the registered read, then reads the column and row symbols and forms the
// result. A decrypting beat scans both symbol lists, then reads the square entry.
// Reset clears the sequencer, position, mode and output valid; the key memories have none.
// A waiting result blocks no load; a data beat holds at its end until the result is taken.
module fractionating_byte_cipher (
    input  logic       i_clk,
    input  logic       i_rst_n,
    fbc_in_if.sink     i_in,
    fbc_out_if.source  o_out,
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata
);

    fbc_pkg::t_state   r_state;
    fbc_pkg::t_key_req s_req;

    logic       r_mode;
    logic [3:0] r_pos;
    logic [3:0] r_k;
    logic [7:0] r_val;
    logic [7:0] r_cnt;
    logic       r_pend;
    logic [7:0] r_pend_idx;
    logic [3:0] r_c;
    logic [3:0] r_r;
    logic [7:0] r_hi;
    logic       r_out_valid;
    logic [7:0] r_out_byte;

    logic [7:0] s_sym_rdata;
    logic [7:0] s_sq_rdata;
    logic       s_acc;
    logic       s_data_acc;
    logic [3:0] s_k;
    logic [8:0] s_sq_off;
    logic [7:0] s_nib_cmp;
    logic       s_sym_hit;
    logic       s_sq_hit;
    logic       s_can_emit;
    logic       s_emit;

    assign s_acc      = i_in.valid && i_in.ready;
    assign s_data_acc = s_acc && (i_in.op == fbc_pkg::OP_DATA);
    assign s_k        = i_in.first ? 4'd0 : r_pos;
    assign s_sq_off   = i_in.key_index - 9'(fbc_pkg::SYM_BYTES);
    assign s_can_emit = !r_out_valid || o_out.ready;

    // A new result is loaded into the output register in this cycle.
    assign s_emit = s_can_emit
                    && ((r_state == fbc_pkg::S_ENC_FIN) || (r_state == fbc_pkg::S_DEC_FIN));

    assign i_in.ready     = (r_state == fbc_pkg::S_IDLE);
    assign o_out.valid    = r_out_valid;
    assign o_out.out_byte = r_out_byte;

    // Compare unit: the pending memory read against the search target.
    assign s_nib_cmp = (r_state == fbc_pkg::S_DEC_CSCAN) ? {4'h0, r_val[7:4]}
                                                         : {4'h0, r_val[3:0]};
    assign s_sym_hit = r_pend && (s_sym_rdata == s_nib_cmp);
    assign s_sq_hit  = r_pend && (s_sq_rdata == r_val);

    // Key store access: writes straight from a load beat, reads per state.
    always_comb begin
        s_req.sym_we    = s_acc && (i_in.op == fbc_pkg::OP_LOAD)
                          && (i_in.key_index < 9'(fbc_pkg::SYM_BYTES));
        s_req.sym_waddr = i_in.key_index[4:0];
        s_req.sq_we     = s_acc && (i_in.op == fbc_pkg::OP_LOAD)
                          && (i_in.key_index >= 9'(fbc_pkg::SYM_BYTES))
                          && (i_in.key_index < 9'(fbc_pkg::KEY_BYTES));
        s_req.sq_waddr  = s_sq_off[7:0];
        s_req.wdata     = i_in.value;
        s_req.sym_raddr = '0;
        s_req.sq_raddr  = {r_cnt[3:0], r_cnt[7:4]};
        unique case (r_state)
            fbc_pkg::S_ENC_COL: begin
                s_req.sym_raddr = {1'b0, r_c + r_k};
            end
            fbc_pkg::S_ENC_ROW, fbc_pkg::S_ENC_FIN: begin
                s_req.sym_raddr = {1'b1, r_r + r_k};
            end
            fbc_pkg::S_DEC_CSCAN: begin
                s_req.sym_raddr = {1'b0, r_cnt[3:0]};
            end
            fbc_pkg::S_DEC_RSCAN: begin
                s_req.sym_raddr = {1'b1, r_cnt[3:0]};
            end
            fbc_pkg::S_DEC_READ, fbc_pkg::S_DEC_FIN: begin
                s_req.sq_raddr = {r_r - r_k, r_c - r_k};
            end
            default: begin
            end
        endcase
    end

    fbc_key_mem u_key_mem (
        .i_clk       (i_clk),
        .i_req       (s_req),
        .o_sym_rdata (s_sym_rdata),
        .o_sq_rdata  (s_sq_rdata)
    );

    // Mode register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= fbc_pkg::MODE_ENC;
        end else if (i_cfg_we) begin
            r_mode <= i_cfg_wdata;
        end
    end

    // Sequencer, scan pipeline and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= fbc_pkg::S_IDLE;
            r_pos       <= '0;
            r_pend      <= 1'b0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && o_out.ready && !s_emit) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                fbc_pkg::S_IDLE: begin
                    r_cnt  <= '0;
                    r_pend <= 1'b0;
                    if (s_data_acc) begin
                        r_val <= i_in.value;
                        r_k   <= s_k;
                        r_pos <= s_k + 4'd1;
                        r_state <= (r_mode == fbc_pkg::MODE_ENC) ? fbc_pkg::S_ENC_SCAN
                                                                 : fbc_pkg::S_DEC_CSCAN;
                    end
                end
                fbc_pkg::S_ENC_SCAN: begin
                    // Counter runs column-major: {col, row}.
                    if (s_sq_hit) begin
                        r_c     <= r_pend_idx[7:4];
                        r_r     <= r_pend_idx[3:0];
                        r_pend  <= 1'b0;
                        r_state <= fbc_pkg::S_ENC_COL;
                    end else if (r_pend && (r_pend_idx == 8'hFF)) begin
                        r_c     <= '0;
                        r_r     <= '0;
                        r_pend  <= 1'b0;
                        r_state <= fbc_pkg::S_ENC_COL;
                    end else begin
                        r_pend     <= 1'b1;
                        r_pend_idx <= r_cnt;
                        r_cnt      <= r_cnt + 8'd1;
                    end
                end
                fbc_pkg::S_ENC_COL: begin
                    r_state <= fbc_pkg::S_ENC_ROW;
                end
                fbc_pkg::S_ENC_ROW: begin
                    r_hi    <= s_sym_rdata;
                    r_state <= fbc_pkg::S_ENC_FIN;
                end
                fbc_pkg::S_ENC_FIN: begin
                    if (s_can_emit) begin
                        r_out_valid <= 1'b1;
                        r_out_byte  <= {r_hi[3:0], 4'h0} ^ s_sym_rdata;
                        r_state     <= fbc_pkg::S_IDLE;
                    end
                end
                fbc_pkg::S_DEC_CSCAN: begin
                    if (s_sym_hit || (r_pend && (r_pend_idx[3:0] == 4'hF))) begin
                        r_c     <= s_sym_hit ? r_pend_idx[3:0] : 4'd0;
                        r_pend  <= 1'b0;
                        r_cnt   <= '0;
                        r_state <= fbc_pkg::S_DEC_RSCAN;
                    end else begin
                        r_pend     <= 1'b1;
                        r_pend_idx <= r_cnt;
                        r_cnt      <= r_cnt + 8'd1;
                    end
                end
                fbc_pkg::S_DEC_RSCAN: begin
                    if (s_sym_hit || (r_pend && (r_pend_idx[3:0] == 4'hF))) begin
                        r_r     <= s_sym_hit ? r_pend_idx[3:0] : 4'd0;
                        r_pend  <= 1'b0;
                        r_state <= fbc_pkg::S_DEC_READ;
                    end else begin
                        r_pend     <= 1'b1;
                        r_pend_idx <= r_cnt;
                        r_cnt      <= r_cnt + 8'd1;
                    end
                end
                fbc_pkg::S_DEC_READ: begin
                    r_state <= fbc_pkg::S_DEC_FIN;
                end
                fbc_pkg::S_DEC_FIN: begin
                    if (s_can_emit) begin
                        r_out_valid <= 1'b1;
                        r_out_byte  <= s_sq_rdata;
                        r_state     <= fbc_pkg::S_IDLE;
                    end
                end
                default: begin
                    r_state <= fbc_pkg::S_IDLE;
                end
            endcase
        end
    end

    // A data beat makes the block busy on the next cycle.
    a_busy_after_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_data_acc |=> !i_in.ready)
        else $error("block still ready after a data beat");

    // A message start leaves the position at one.
    a_first_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_data_acc && i_in.first |=> r_pos == 4'd1)
        else $error("position not restarted by first");

    // No read is in flight while the block waits for a new beat.
    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready |-> !r_pend)
        else $error("scan pipeline not drained in idle");

    // The sequencer state stays one-hot.
    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("sequencer state not one-hot");

endmodule

// ===== test/fbc_cipher_checker.sv =====
// Scoreboard for the fractionating byte cipher: mirrors the key, position and mode,
// predicts each result byte and compares it with what the block hands out.
// Depends on fbc_pkg and the channel interfaces in fbc_if.
`timescale 1ns / 1ps

module fbc_cipher_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    fbc_in_if    i_in,
    fbc_out_if   i_out,
    input  logic i_cfg_we,
    input  logic i_cfg_wdata,
    output int   o_errors,
    output int   o_pending
);

    // Mirror of the key store, the message position and the mode register.
    logic [7:0] col_sym [0:fbc_pkg::SIDE-1];
    logic [7:0] row_sym [0:fbc_pkg::SIDE-1];
    logic [7:0] sq [0:fbc_pkg::SIDE*fbc_pkg::SIDE-1];
    logic [3:0] msg_pos;
    logic       cipher_mode;

    logic [7:0] expected_bytes [$];
    int         error_count;
    int         pending_count;

    assign o_errors  = error_count;
    assign o_pending = pending_count;

    initial begin
        error_count   = 0;
        pending_count = 0;
        msg_pos       = '0;
        cipher_mode   = fbc_pkg::MODE_ENC;
    end

    // Works out the output byte for one data byte at message position k.
    function automatic logic [7:0] cipher_byte(input logic [7:0] b, input logic [3:0] k);
        logic [3:0] c;
        logic [3:0] r;
        logic [3:0] cs;
        logic [3:0] rs;
        logic       hit_c;
        logic       hit_r;
        c     = '0;
        r     = '0;
        hit_c = 1'b0;
        hit_r = 1'b0;
        if (cipher_mode == fbc_pkg::MODE_ENC) begin
            // Column-major search of the square; a miss leaves both indexes at zero.
            for (int ci = 0; ci < fbc_pkg::SIDE; ci++) begin
                for (int ri = 0; ri < fbc_pkg::SIDE; ri++) begin
                    if (!hit_c && sq[{ri[3:0], ci[3:0]}] == b) begin
                        hit_c = 1'b1;
                        c     = ci[3:0];
                        r     = ri[3:0];
                    end
                end
            end
            cs = c + k;
            rs = r + k;
            return {col_sym[cs][3:0], 4'h0} ^ row_sym[rs];
        end else begin
            // Each nibble is matched against the full 8-bit symbols, first hit wins.
            for (int i = 0; i < fbc_pkg::SIDE; i++) begin
                if (!hit_c && col_sym[i] == {4'h0, b[7:4]}) begin
                    hit_c = 1'b1;
                    c     = i[3:0];
                end
                if (!hit_r && row_sym[i] == {4'h0, b[3:0]}) begin
                    hit_r = 1'b1;
                    r     = i[3:0];
                end
            end
            cs = c - k;
            rs = r - k;
            return sq[{rs, cs}];
        end
    endfunction

    // Follow every beat on both channels and every register write.
    always @(posedge i_clk) begin : track
        logic [3:0] k;
        logic [7:0] want;
        logic [8:0] sq_at;
        if (!i_rst_n) begin
            msg_pos     = '0;
            cipher_mode = fbc_pkg::MODE_ENC;
            expected_bytes.delete();
        end else begin
            if (i_in.valid && i_in.ready) begin
                if (i_in.op == fbc_pkg::OP_LOAD) begin
                    // Key writes past the end of the key are dropped.
                    if (i_in.key_index < fbc_pkg::SIDE) begin
                        col_sym[i_in.key_index[3:0]] = i_in.value;
                    end else if (i_in.key_index < fbc_pkg::SYM_BYTES) begin
                        row_sym[i_in.key_index[3:0]] = i_in.value;
                    end else if (i_in.key_index < fbc_pkg::KEY_BYTES) begin
                        sq_at = i_in.key_index - 9'(fbc_pkg::SYM_BYTES);
                        sq[sq_at[7:0]] = i_in.value;
                    end
                end else begin
                    k = i_in.first ? 4'd0 : msg_pos;
                    expected_bytes.push_back(cipher_byte(i_in.value, k));
                    msg_pos = k + 4'd1;
                end
            end
            if (i_out.valid && i_out.ready) begin
                if (expected_bytes.size() == 0) begin
                    $error("out_byte: expected nothing, actual %02h", i_out.out_byte);
                    error_count++;
                end else begin
                    want = expected_bytes.pop_front();
                    if (want !== i_out.out_byte) begin
                        $error("out_byte: expected %02h, actual %02h", want, i_out.out_byte);
                        error_count++;
                    end
                end
            end
            if (i_cfg_we) begin
                cipher_mode = i_cfg_wdata;
            end
        end
        pending_count = expected_bytes.size();
    end

endmodule

// ===== test/tb_top.sv =====
// Top of the cipher testbench: clock, reset, key loads, data messages and handshake
// pressure; the verdict comes from the checker beside the block.
// Depends on fbc_pkg, fbc_if, fractionating_byte_cipher and fbc_cipher_checker.
`timescale 1ns / 1ps

module tb_top;

    localparam int SETTLE_CYCLES  = 300;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PHASES         = 6;
    localparam int PHASE_ITEMS    = 40;

    typedef enum int {KEY_PERM, KEY_DUP, KEY_WIDE} t_key_kind;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_wdata;
    int   error_count;
    int   pending;
    int   idle_cycles;

    // Copy of the key as loaded, used to shape the data bytes and the directed key writes.
    logic [7:0] key_image [0:fbc_pkg::KEY_BYTES-1];
    logic [7:0] key_draft [0:fbc_pkg::KEY_BYTES-1];
    logic       cur_mode;
    logic       in_quiet;
    logic       out_quiet;
    int         data_sent;

    fbc_in_if  in_ch ();
    fbc_out_if out_ch ();

    fractionating_byte_cipher i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in        (in_ch),
        .o_out       (out_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    fbc_cipher_checker i_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in        (in_ch),
        .i_out       (out_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .o_errors    (error_count),
        .o_pending   (pending)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // Watchdog: too long without a beat on either channel ends the run.
    initial idle_cycles = 0;
    always @(posedge clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    // Result side: a random stall before each beat, none in quiet stretches.
    initial begin : result_sink
        int stall;
        out_ch.ready = 1'b0;
        @(negedge clk);
        while (!rst_n) @(negedge clk);
        forever begin
            stall = out_quiet ? 0 : $urandom_range(0, 8);
            if (stall != 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge clk);
            while (!(out_ch.valid && out_ch.ready)) @(posedge clk);
            @(negedge clk);
        end
    end

    // Sends one beat after a random gap and waits for it to be taken.
    task automatic put_item(input logic op, input logic [8:0] idx, input logic [7:0] val,
                            input logic first);
        int gap;
        gap = in_quiet ? 0 : $urandom_range(0, 8);
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.op        <= op;
        in_ch.key_index <= idx;
        in_ch.value     <= val;
        in_ch.first     <= first;
        in_ch.valid     <= 1'b1;
        @(posedge clk);
        while (!(in_ch.valid && in_ch.ready)) @(posedge clk);
        @(negedge clk);
        if (op == fbc_pkg::OP_LOAD && idx < fbc_pkg::KEY_BYTES) begin
            key_image[idx] = val;
        end else if (op == fbc_pkg::OP_DATA) begin
            data_sent++;
        end
    endtask

    // Stops sending until every result is back, then lets the block settle.
    task automatic hold_until_drained(input int settle);
        in_ch.valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
        repeat (settle) @(negedge clk);
    endtask

    task automatic set_mode(input logic m);
        hold_until_drained(SETTLE_CYCLES);
        cfg_we    <= 1'b1;
        cfg_wdata <= m;
        @(negedge clk);
        cfg_we    <= 1'b0;
        cur_mode = m;
    endtask

    task automatic shuffle_draft(input int lo, input int hi);
        int j;
        logic [7:0] t;
        for (int i = hi; i > lo; i--) begin
            j = $urandom_range(lo, i);
            t = key_draft[i];
            key_draft[i] = key_draft[j];
            key_draft[j] = t;
        end
    endtask

    // Builds a whole key of the given kind and writes it in random order.
    task automatic load_key(input t_key_kind kind);
        int order [0:fbc_pkg::KEY_BYTES-1];
        int j;
        int t;
        for (int i = 0; i < fbc_pkg::KEY_BYTES; i++) begin
            case (kind)
                KEY_PERM: begin
                    key_draft[i] = (i < fbc_pkg::SYM_BYTES) ? 8'(i % fbc_pkg::SIDE)
                                                            : 8'(i - fbc_pkg::SYM_BYTES);
                end
                KEY_DUP: begin
                    key_draft[i] = (i < fbc_pkg::SYM_BYTES) ? 8'($urandom_range(0, 15))
                                                            : 8'($urandom);
                end
                default: begin
                    key_draft[i] = (i < fbc_pkg::SYM_BYTES) ? 8'($urandom)
                                                            : 8'($urandom_range(0, 31));
                end
            endcase
            order[i] = i;
        end
        if (kind == KEY_PERM) begin
            shuffle_draft(0, fbc_pkg::SIDE - 1);
            shuffle_draft(fbc_pkg::SIDE, fbc_pkg::SYM_BYTES - 1);
            shuffle_draft(fbc_pkg::SYM_BYTES, fbc_pkg::KEY_BYTES - 1);
        end
        for (int i = fbc_pkg::KEY_BYTES - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            t = order[i];
            order[i] = order[j];
            order[j] = t;
        end
        for (int i = 0; i < fbc_pkg::KEY_BYTES; i++) begin
            put_item(fbc_pkg::OP_LOAD, 9'(order[i]), key_draft[order[i]], 1'($urandom));
        end
    endtask

    // Plaintext mostly taken from the square, so the search usually hits.
    function automatic logic [7:0] pick_plain();
        if ($urandom_range(0, 7) == 0) begin
            return 8'($urandom);
        end
        return key_image[fbc_pkg::SYM_BYTES + $urandom_range(0, 255)];
    endfunction

    // Ciphertext mostly built from symbol nibbles, so the lookups usually hit.
    function automatic logic [7:0] pick_cipher();
        if ($urandom_range(0, 7) == 0) begin
            return 8'($urandom);
        end
        return {key_image[$urandom_range(0, 15)][3:0],
                key_image[fbc_pkg::SIDE + $urandom_range(0, 15)][3:0]};
    endfunction

    // One message: a byte usually flagged first, then data bytes, with stray key writes in between.
    task automatic send_message();
        int len;
        logic [7:0] b;
        logic fst;
        len = $urandom_range(1, 40);
        if ($urandom_range(0, 29) == 0) begin
            hold_until_drained(0);
        end
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 24) == 0) begin
                put_item(fbc_pkg::OP_LOAD, 9'($urandom_range(0, 511)), 8'($urandom),
                         1'($urandom));
            end
            b   = (cur_mode == fbc_pkg::MODE_ENC) ? pick_plain() : pick_cipher();
            fst = (i == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 39) == 0);
            put_item(fbc_pkg::OP_DATA, 9'($urandom), b, fst);
        end
    endtask

    initial begin : stimulus
        logic [7:0] lost;
        int phase_start;
        in_ch.valid     = 1'b0;
        in_ch.op        = fbc_pkg::OP_LOAD;
        in_ch.key_index = '0;
        in_ch.value     = '0;
        in_ch.first     = 1'b0;
        cfg_we          = 1'b0;
        cfg_wdata       = 1'b0;
        rst_n           = 1'b0;
        in_quiet        = 1'b0;
        out_quiet       = 1'b0;
        data_sent       = 0;
        cur_mode        = fbc_pkg::MODE_ENC;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        // Directed encryption on a permutation key.
        set_mode(fbc_pkg::MODE_ENC);
        load_key(KEY_PERM);
        put_item(fbc_pkg::OP_LOAD, 9'd288, 8'hFF, 1'b1);
        put_item(fbc_pkg::OP_LOAD, 9'd511, 8'h00, 1'b0);
        put_item(fbc_pkg::OP_DATA, 9'd0, 8'h00, 1'b1);
        put_item(fbc_pkg::OP_DATA, 9'h1FF, 8'hFF, 1'b0);
        // Run the position past 15 so it wraps.
        for (int i = 0; i < 15; i++) begin
            put_item(fbc_pkg::OP_DATA, 9'($urandom), 8'($urandom), 1'b0);
        end
        // Duplicate one square byte so the overwritten value can no longer be found;
        // the key write carries a first flag that must not touch the position.
        lost = key_image[fbc_pkg::KEY_BYTES - 1];
        put_item(fbc_pkg::OP_LOAD, 9'(fbc_pkg::KEY_BYTES - 1),
                 key_image[fbc_pkg::KEY_BYTES - 2], 1'b1);
        put_item(fbc_pkg::OP_DATA, 9'd5, lost, 1'b0);
        put_item(fbc_pkg::OP_DATA, 9'd6, key_image[fbc_pkg::KEY_BYTES - 2], 1'b0);

        // Directed decryption, including a column symbol that no longer matches.
        set_mode(fbc_pkg::MODE_DEC);
        put_item(fbc_pkg::OP_DATA, 9'd0, 8'h00, 1'b1);
        put_item(fbc_pkg::OP_DATA, 9'd0, 8'hFF, 1'b0);
        lost = key_image[0];
        put_item(fbc_pkg::OP_LOAD, 9'd0, 8'hF0, 1'b0);
        put_item(fbc_pkg::OP_DATA, 9'd0, {lost[3:0], key_image[fbc_pkg::SIDE][3:0]}, 1'b0);

        // Random phases: alternate modes, new keys, quiet and busy handshakes.
        for (int ph = 0; ph < PHASES; ph++) begin
            set_mode((ph % 2 == 0) ? fbc_pkg::MODE_DEC : fbc_pkg::MODE_ENC);
            in_quiet  = (ph == 0) || ($urandom_range(0, 3) == 0);
            out_quiet = (ph == 0) || ($urandom_range(0, 3) == 0);
            if ((ph % 2 == 0) && (ph != 0)) begin
                load_key(t_key_kind'((ph / 2) % 3));
            end
            phase_start = data_sent;
            while (data_sent - phase_start < PHASE_ITEMS) begin
                send_message();
            end
        end

        hold_until_drained(SETTLE_CYCLES);
        if (error_count == 0 && pending == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule
